### design/tkrq_pkg.sv
// ----------------------------------------------------------------------------
// tkrq_pkg
// Shared types, key layout and register codes for the touch keypad qualifier.
// ----------------------------------------------------------------------------
package tkrq_pkg;

    localparam int NUM_KEYS_DEF   = 9;
    localparam int COUNT_BITS_DEF = 8;

    localparam int LAYOUT_KEYS = 9;
    localparam int MASK_W      = 9;
    localparam int COORD_W     = 10;
    localparam int SIZE_W      = 10;
    localparam int LIMIT_W     = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_KEY_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLICK_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY = 2'd2;

    localparam logic [SIZE_W-1:0]  KEY_SIZE_RST     = 10'd40;
    localparam logic [LIMIT_W-1:0] CLICK_LIMIT_RST  = 8'd8;
    localparam logic [LIMIT_W-1:0] REPEAT_DELAY_RST = 8'd15;

    // Top-left corners: up, down, left, right, a, b, x, y, start.
    localparam logic [COORD_W-1:0] KEY_PX [LAYOUT_KEYS] =
        '{10'd50, 10'd50, 10'd10, 10'd90, 10'd270, 10'd230, 10'd230, 10'd190, 10'd140};
    localparam logic [COORD_W-1:0] KEY_PY [LAYOUT_KEYS] =
        '{10'd300, 10'd380, 10'd340, 10'd340, 10'd340, 10'd380, 10'd300, 10'd340, 10'd440};

    typedef struct packed {
        logic               touch_valid;
        logic [COORD_W-1:0] touch_x;
        logic [COORD_W-1:0] touch_y;
        logic               tick_end;
    } t_touch;

    typedef struct packed {
        logic [MASK_W-1:0] held_mask;
        logic [MASK_W-1:0] press_mask;
        logic [MASK_W-1:0] release_mask;
        logic [MASK_W-1:0] click_mask;
        logic [MASK_W-1:0] repeat_mask;
    } t_result;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } t_cfg_write;

    typedef struct packed {
        logic [SIZE_W-1:0]  key_size;
        logic [LIMIT_W-1:0] click_limit;
        logic [LIMIT_W-1:0] repeat_delay;
    } t_cfg;

endpackage

### design/tkrq_ifs.sv
// ----------------------------------------------------------------------------
// tkrq channel interfaces
// Valid/ready channels for touch points, results and register writes.
// ----------------------------------------------------------------------------
interface tkrq_touch_if;
    logic            valid;
    logic            ready;
    tkrq_pkg::t_touch data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tkrq_result_if;
    logic             valid;
    logic             ready;
    tkrq_pkg::t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tkrq_cfg_if;
    logic                valid;
    logic                ready;
    tkrq_pkg::t_cfg_write data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/tkrq_hit.sv
// ----------------------------------------------------------------------------
// tkrq_hit
// Hit test of one point against the key areas; first matching key wins.
// ----------------------------------------------------------------------------
module tkrq_hit #(
    parameter int NUM_KEYS = tkrq_pkg::NUM_KEYS_DEF,
    localparam int ACTIVE  = (NUM_KEYS < tkrq_pkg::LAYOUT_KEYS) ? NUM_KEYS
                                                                : tkrq_pkg::LAYOUT_KEYS
) (
    input  logic                         i_point_valid,
    input  logic [tkrq_pkg::COORD_W-1:0] i_x,
    input  logic [tkrq_pkg::COORD_W-1:0] i_y,
    input  logic [tkrq_pkg::SIZE_W-1:0]  i_key_size,
    output logic [ACTIVE-1:0]            o_hit
);
    localparam int SUM_W  = tkrq_pkg::COORD_W + 1;

    logic [ACTIVE-1:0] inside_area;

    for (genvar k = 0; k < ACTIVE; k++) begin : g_key
        logic [SUM_W-1:0] x_hi;
        logic [SUM_W-1:0] y_hi;
        assign x_hi = {1'b0, tkrq_pkg::KEY_PX[k]} + {1'b0, i_key_size};
        assign y_hi = {1'b0, tkrq_pkg::KEY_PY[k]} + {1'b0, i_key_size};
        assign inside_area[k] = (i_x >= tkrq_pkg::KEY_PX[k]) && ({1'b0, i_x} <= x_hi)
                             && (i_y >= tkrq_pkg::KEY_PY[k]) && ({1'b0, i_y} <= y_hi);
    end

    // Keep only the lowest matching key.
    always_comb begin
        logic found;
        found = 1'b0;
        o_hit = '0;
        for (int k = 0; k < ACTIVE; k++) begin
            if (inside_area[k] && !found && i_point_valid) begin
                o_hit[k] = 1'b1;
                found    = 1'b1;
            end
        end
    end
endmodule

### design/tkrq_track.sv
// ----------------------------------------------------------------------------
// tkrq_track
// Per-tick hit collection, hold counters and the registered result.
// ----------------------------------------------------------------------------
module tkrq_track #(
    parameter int NUM_KEYS   = tkrq_pkg::NUM_KEYS_DEF,
    parameter int COUNT_BITS = tkrq_pkg::COUNT_BITS_DEF,
    localparam int ACTIVE    = (NUM_KEYS < tkrq_pkg::LAYOUT_KEYS) ? NUM_KEYS
                                                                  : tkrq_pkg::LAYOUT_KEYS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_tick_end,
    input  logic [ACTIVE-1:0]     i_hit,
    input  tkrq_pkg::t_cfg        i_cfg,
    output logic                  o_out_free,
    tkrq_result_if.source         o_result
);
    localparam int CW = (COUNT_BITS > tkrq_pkg::LIMIT_W) ? COUNT_BITS : tkrq_pkg::LIMIT_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
    localparam logic [COUNT_BITS-1:0] CNT_BACK = CNT_MAX - COUNT_BITS'(3);

    logic [ACTIVE-1:0]     r_tick_hits, n_tick_hits;
    logic [ACTIVE-1:0]     r_prev_held;
    logic [COUNT_BITS-1:0] r_hold_count [ACTIVE];
    logic [COUNT_BITS-1:0] n_hold_count [ACTIVE];
    logic                  r_out_v;
    tkrq_pkg::t_result     r_out;

    logic [ACTIVE-1:0] held, press, rel, click, rpt;
    logic              close_tick;

    assign o_out_free = !r_out_v || o_result.ready;
    assign close_tick = i_step && i_tick_end;
    assign held       = r_tick_hits | i_hit;
    assign n_tick_hits = i_tick_end ? '0 : held;

    always_comb begin
        for (int k = 0; k < ACTIVE; k++) begin
            press[k] = held[k] && !r_prev_held[k];
            rel[k]   = !held[k] && r_prev_held[k];
            click[k] = rel[k] && (CW'(r_hold_count[k]) <= CW'(i_cfg.click_limit));
            rpt[k]   = press[k] || (held[k]
                       && (CW'(r_hold_count[k]) > CW'(i_cfg.repeat_delay))
                       && (r_hold_count[k][1:0] == 2'b00));
            if (!held[k]) begin
                n_hold_count[k] = '0;
            end else if (r_hold_count[k] == CNT_MAX) begin
                n_hold_count[k] = CNT_BACK;
            end else begin
                n_hold_count[k] = r_hold_count[k] + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_hits <= '0;
            r_prev_held <= '0;
            r_out_v     <= 1'b0;
            for (int k = 0; k < ACTIVE; k++) begin
                r_hold_count[k] <= '0;
            end
        end else begin
            if (i_step) begin
                r_tick_hits <= n_tick_hits;
            end
            if (close_tick) begin
                r_prev_held <= held;
                for (int k = 0; k < ACTIVE; k++) begin
                    r_hold_count[k] <= n_hold_count[k];
                end
            end
            if (close_tick) begin
                r_out_v <= 1'b1;
            end else if (o_result.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (close_tick) begin
            r_out.held_mask    <= tkrq_pkg::MASK_W'(held);
            r_out.press_mask   <= tkrq_pkg::MASK_W'(press);
            r_out.release_mask <= tkrq_pkg::MASK_W'(rel);
            r_out.click_mask   <= tkrq_pkg::MASK_W'(click);
            r_out.repeat_mask  <= tkrq_pkg::MASK_W'(rpt);
        end
    end

    assign o_result.valid = r_out_v;
    assign o_result.data  = r_out;

    a_close_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        close_tick |=> r_out_v && (r_tick_hits == '0))
        else $error("closed tick did not load result or clear hits");

    a_prev_matches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (tkrq_pkg::MASK_W'(r_prev_held) == r_out.held_mask))
        else $error("previous held mask out of step with result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        close_tick |-> (!r_out_v || o_result.ready))
        else $error("result overwritten while waiting");

    a_mask_relations: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> ((r_out.press_mask & ~r_out.repeat_mask) == '0)
                 && ((r_out.click_mask & ~r_out.release_mask) == '0)
                 && ((r_out.release_mask & r_out.held_mask) == '0))
        else $error("inconsistent result masks");
endmodule

### design/touch_keypad_repeat_qualifier.sv
// ----------------------------------------------------------------------------
// touch_keypad_repeat_qualifier
// Hit-tests touch points against up to nine keys and qualifies press, release,
// click and auto-repeat once per tick.
// ----------------------------------------------------------------------------
// Result path: a tick_end point loads the input register on acceptance,
//   and the tick's result loads the result register when that point steps on.
// Throughput: one point per cycle; a tick_end point waits in the input
//   register only while an earlier result is still not taken.
// Reset: synchronous active-low; clears hit mask, held mask, hold counters
//   and valids, and loads key_size 40, click_limit 8, repeat_delay 15.
module touch_keypad_repeat_qualifier #(
    parameter int NUM_KEYS   = tkrq_pkg::NUM_KEYS_DEF,
    parameter int COUNT_BITS = tkrq_pkg::COUNT_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tkrq_touch_if.sink    i_touch,
    tkrq_cfg_if.sink      i_cfg,
    tkrq_result_if.source o_result
);
    localparam int ACTIVE = (NUM_KEYS < tkrq_pkg::LAYOUT_KEYS) ? NUM_KEYS
                                                                : tkrq_pkg::LAYOUT_KEYS;

    // Configuration registers; the user must write them only while the block is idle (not enforced here).
    tkrq_pkg::t_cfg r_cfg;

    // Input register holding one touch request.
    logic             r_in_v;
    tkrq_pkg::t_touch r_in;

    logic              out_free;
    logic              step;
    logic [ACTIVE-1:0] hit;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_size     <= tkrq_pkg::KEY_SIZE_RST;
            r_cfg.click_limit  <= tkrq_pkg::CLICK_LIMIT_RST;
            r_cfg.repeat_delay <= tkrq_pkg::REPEAT_DELAY_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                tkrq_pkg::REG_KEY_SIZE: begin
                    r_cfg.key_size <= i_cfg.data.value[tkrq_pkg::SIZE_W-1:0];
                end
                tkrq_pkg::REG_CLICK_LIMIT: begin
                    r_cfg.click_limit <= i_cfg.data.value[tkrq_pkg::LIMIT_W-1:0];
                end
                tkrq_pkg::REG_REPEAT_DELAY: begin
                    r_cfg.repeat_delay <= i_cfg.data.value[tkrq_pkg::LIMIT_W-1:0];
                end
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    // Advance the held request unless it closes a tick and the result slot
    // is still occupied.
    assign step          = r_in_v && (!r_in.tick_end || out_free);
    assign i_touch.ready = !r_in_v || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (i_touch.ready) begin
            r_in_v <= i_touch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_touch.ready && i_touch.valid) begin
            r_in <= i_touch.data;
        end
    end

    tkrq_hit #(
        .NUM_KEYS (NUM_KEYS)
    ) u_hit (
        .i_point_valid (r_in.touch_valid),
        .i_x           (r_in.touch_x),
        .i_y           (r_in.touch_y),
        .i_key_size    (r_cfg.key_size),
        .o_hit         (hit)
    );

    tkrq_track #(
        .NUM_KEYS   (NUM_KEYS),
        .COUNT_BITS (COUNT_BITS)
    ) u_track (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_tick_end (r_in.tick_end),
        .i_hit      (hit),
        .i_cfg      (r_cfg),
        .o_out_free (out_free),
        .o_result   (o_result)
    );
endmodule
